// ----- hdl/gsac_pkg.sv -----
// Package for the segment age cluster selector.
// Holds the default sizes and the command and status structs between controller and datapath.
package gsac_pkg;

  localparam int unsigned MaxCandidatesDef = 1024;
  localparam int unsigned MaxSelectDef     = 32;

  localparam logic [1:0] REG_NOW_TIME   = 2'd0;
  localparam logic [1:0] REG_PROTECT    = 2'd1;
  localparam logic [1:0] REG_AGE_WINDOW = 2'd2;
  localparam logic [1:0] REG_BLOCKS     = 2'd3;

  typedef struct packed {
    logic scan_start;
    logic commit;
    logic clear_run;
    logic out_load;
    logic out_last;
    logic out_none;
  } gsac_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic found;
    logic in_win;
    logic fill_done;
    logic first;
  } gsac_sts_t;

endpackage

// ----- hdl/gc_segment_age_cluster_select.sv -----
// Top level of the segment age cluster selector.
// Depends on gsac_pkg, gsac_ctrl and gsac_dp.
//
// Channel  | Beat contents                                      | Direction
// s_axis   | descriptor: segment, time, live, assessed; tlast  | in
// m_axis   | selected segment; tuser none/overflow; tlast     | out
// cfg      | register index and write data                     | in
//
// Descriptors are taken at one beat per cycle while collecting.
// After the last beat, each result takes one pass over the store, a decide state and a
// check state. A stalled result beat holds the controller.
// Selection time is set by the single read port of the candidate memory.
// Reset clears the counts at once; the memory needs no clearing pass.
module gc_segment_age_cluster_select import gsac_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandidatesDef,
  parameter int unsigned MAX_SELECT     = MaxSelectDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,  // segment_number, last_modified, live_count, assessed_ok
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,  // selected_segment
  output logic [1:0]   m_axis_tuser_o,  // none_selected, store_overflow
  output logic         m_axis_tlast_o
);

  gsac_cmd_t cmd;
  gsac_sts_t sts;

  gsac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gsac_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_SELECT     (MAX_SELECT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_accept_i (s_axis_tvalid_i && s_axis_tready_o),
    .in_seg_i    (s_axis_tdata_i[31:0]),
    .in_time_i   (s_axis_tdata_i[79:32]),
    .in_live_i   (s_axis_tdata_i[95:80]),
    .in_ok_i     (s_axis_tdata_i[96]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_seg_o   (m_axis_tdata_o),
    .out_none_o  (m_axis_tuser_o[0]),
    .out_ovf_o   (m_axis_tuser_o[1]),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ----- hdl/gsac_dp.sv -----
// Datapath: configuration registers, candidate memory, minimum scan and output register.
// Depends on gsac_pkg.
module gsac_dp import gsac_pkg::*; #(
  parameter int unsigned MAX_CANDIDATES = MaxCandidatesDef,
  parameter int unsigned MAX_SELECT     = MaxSelectDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        in_accept_i,
  input  logic [31:0] in_seg_i,
  input  logic [47:0] in_time_i,
  input  logic [15:0] in_live_i,
  input  logic        in_ok_i,
  input  gsac_cmd_t   cmd_i,
  output gsac_sts_t   sts_o,
  output logic [31:0] out_seg_o,
  output logic        out_none_o,
  output logic        out_ovf_o,
  output logic        out_last_o
);

  localparam int unsigned AW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned CW   = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned NW   = $clog2(MAX_SELECT + 1);
  localparam int unsigned ACW  = 16 + NW;
  localparam int unsigned EW   = 32 + 48 + 16;
  localparam int unsigned KW   = 48 + 32 + AW;
  localparam logic [CW-1:0] CountMax = CW'(MAX_CANDIDATES);
  localparam logic [NW-1:0] SelMax   = NW'(MAX_SELECT);

  logic [47:0] now_q, prot_q;
  logic [15:0] aw_q, bps_q;
  logic [CW-1:0] count_q;
  logic ovf_q;
  logic [EW-1:0] mem_q [MAX_CANDIDATES];
  logic [EW-1:0] rdata_q;
  logic rvalid_q;
  logic [AW-1:0] ridx_q;
  logic [CW-1:0] ra_q;
  logic scan_q;
  logic [KW-1:0] min_key_q, lb_key_q, rkey;
  logic [15:0] min_live_q;
  logic found_q;
  logic [NW-1:0] n_q;
  logic [ACW-1:0] accum_q;
  logic [47:0] seed_q, diff;
  logic [31:0] pend_q;
  logic eligible, wr_en, rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      prot_q <= '0;
      aw_q   <= 16'd4;
      bps_q  <= 16'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NOW_TIME:   now_q  <= cfg_wdata_i;
        REG_PROTECT:    prot_q <= cfg_wdata_i;
        REG_AGE_WINDOW: aw_q   <= cfg_wdata_i[15:0];
        REG_BLOCKS:     bps_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign eligible = in_accept_i && in_ok_i &&
                    !((in_time_i >= prot_q) && (in_time_i <= now_q));
  assign wr_en = eligible && (count_q != CountMax);
  assign rd_en = scan_q && (ra_q != count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= {in_seg_i, in_time_i, in_live_i};
    end
    if (rd_en) begin
      rdata_q <= mem_q[ra_q[AW-1:0]];
      ridx_q  <= ra_q[AW-1:0];
    end
  end

  assign rkey = {rdata_q[63:16], rdata_q[95:64], ridx_q};
  assign diff = min_key_q[KW-1 -: 48] - seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      rvalid_q <= 1'b0;
      ra_q     <= '0;
      scan_q   <= 1'b0;
      found_q  <= 1'b0;
      n_q      <= '0;
      accum_q  <= '0;
    end else begin
      rvalid_q <= rd_en;
      if (rd_en) begin
        ra_q <= ra_q + 1'b1;
      end
      if (wr_en) begin
        count_q <= count_q + 1'b1;
      end else if (eligible) begin
        ovf_q <= 1'b1;
      end
      if (rvalid_q && ((n_q == '0) || (rkey > lb_key_q)) &&
          (!found_q || (rkey < min_key_q))) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        ra_q    <= '0;
        scan_q  <= 1'b1;
        found_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        n_q     <= n_q + 1'b1;
        accum_q <= accum_q + ACW'(min_live_q);
      end
      if (cmd_i.clear_run) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        n_q     <= '0;
        accum_q <= '0;
        scan_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rvalid_q && ((n_q == '0) || (rkey > lb_key_q)) &&
        (!found_q || (rkey < min_key_q))) begin
      min_key_q  <= rkey;
      min_live_q <= rdata_q[15:0];
    end
    if (cmd_i.commit) begin
      lb_key_q <= min_key_q;
      pend_q   <= min_key_q[KW-49 -: 32];
      if (n_q == '0) begin
        seed_q <= min_key_q[KW-1 -: 48];
      end
    end
    if (cmd_i.out_load) begin
      out_seg_o  <= cmd_i.out_none ? 32'd0 : pend_q;
      out_none_o <= cmd_i.out_none;
      out_ovf_o  <= ovf_q;
      out_last_o <= cmd_i.out_last;
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_done  = scan_q && (ra_q == count_q) && !rvalid_q;
  assign sts_o.found      = found_q;
  assign sts_o.first      = (n_q == '0);
  assign sts_o.in_win     = (n_q == '0) || (diff <= {32'd0, aw_q});
  assign sts_o.fill_done  = (accum_q >= ACW'(bps_q)) || (n_q == SelMax);

endmodule

// ----- hdl/gsac_ctrl.sv -----
// Controller: sequences collection, repeated minimum scans and result beats.
// Depends on gsac_pkg.
module gsac_ctrl import gsac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gsac_sts_t sts_i,
  output gsac_cmd_t cmd_o
);

  typedef enum logic [2:0] {S_IN, S_START, S_SCAN, S_DECIDE, S_CHECK} state_e;

  state_e state_q;
  logic out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == S_IN);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IN: ;
      S_START: begin
        if (sts_i.count_zero) begin
          cmd_o.out_load  = out_free;
          cmd_o.out_last  = 1'b1;
          cmd_o.out_none  = 1'b1;
          cmd_o.clear_run = out_free;
        end else begin
          cmd_o.scan_start = 1'b1;
        end
      end
      S_SCAN: ;
      S_DECIDE: begin
        if (!sts_i.found || !sts_i.in_win) begin
          cmd_o.out_load  = out_free;
          cmd_o.out_last  = 1'b1;
          cmd_o.clear_run = out_free;
        end else if (sts_i.first) begin
          cmd_o.commit = 1'b1;
        end else begin
          cmd_o.out_load = out_free;
          cmd_o.commit   = out_free;
        end
      end
      S_CHECK: begin
        if (sts_i.fill_done) begin
          cmd_o.out_load  = out_free;
          cmd_o.out_last  = 1'b1;
          cmd_o.clear_run = out_free;
        end else begin
          cmd_o.scan_start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IN:     if (in_valid_i && in_last_i) state_q <= S_START;
        S_START:  begin
          if (cmd_o.scan_start) state_q <= S_SCAN;
          else if (cmd_o.clear_run) state_q <= S_IN;
        end
        S_SCAN:   if (sts_i.scan_done) state_q <= S_DECIDE;
        S_DECIDE: begin
          if (cmd_o.clear_run) state_q <= S_IN;
          else if (cmd_o.commit) state_q <= S_CHECK;
        end
        S_CHECK:  begin
          if (cmd_o.scan_start) state_q <= S_SCAN;
          else if (cmd_o.clear_run) state_q <= S_IN;
        end
        default:  state_q <= S_IN;
      endcase
    end
  end

endmodule

// ----- hdl/gsac_checker.sv -----
// Port-level checker for the segment age cluster selector, bound to the top level.
// Depends on the top level's ports only.
module gsac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == 32'd0))
    else $error("empty result is not a single last beat");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind gc_segment_age_cluster_select gsac_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- verif/tb_gc_segment_age_cluster_select.sv -----
// Self-checking testbench for the segment age cluster selector.
// Depends on gsac_pkg and gc_segment_age_cluster_select; predicts each selection run.
module tb_gc_segment_age_cluster_select;
  import gsac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCand = MaxCandidatesDef;
  localparam int unsigned NumSel  = MaxSelectDef;
  localparam int unsigned StallLimit = 400000;

  typedef struct packed {
    logic [31:0] seg;
    logic        none;
    logic        ovf;
    logic        last;
  } pick_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [47:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  gc_segment_age_cluster_select dut (.*);

  always #4 clk_i = ~clk_i;

  logic [47:0] now_r = '0, prot_r = '0;
  logic [15:0] win_r = 16'd4, bps_r = 16'd2048;
  logic [31:0] c_seg [NumCand];
  logic [47:0] c_tim [NumCand];
  logic [15:0] c_liv [NumCand];
  int unsigned c_cnt = 0;
  bit          c_ovf = 0;
  pick_t       picks_q [$];
  int          errors = 0;
  bit          sink_idle = 1;
  bit          hold_sink = 0;
  bit          src_idle = 1;
  int unsigned quiet = 0;

  task automatic predict_beat(logic [31:0] seg, logic [47:0] tm, logic [15:0] lv,
                              bit ok, bit last);
    logic [31:0] s; logic [47:0] t; logic [15:0] l;
    int j, n;
    logic [31:0] acc;
    if (ok && !(tm >= prot_r && tm <= now_r)) begin
      if (c_cnt < NumCand) begin
        c_seg[c_cnt] = seg; c_tim[c_cnt] = tm; c_liv[c_cnt] = lv; c_cnt++;
      end else c_ovf = 1;
    end
    if (!last) return;
    if (c_cnt == 0) begin
      picks_q.push_back('{32'd0, 1'b1, c_ovf, 1'b1});
    end else begin
      for (int i = 1; i < c_cnt; i++) begin
        s = c_seg[i]; t = c_tim[i]; l = c_liv[i]; j = i;
        while (j > 0 && (c_tim[j-1] != t ? c_tim[j-1] > t : c_seg[j-1] > s)) begin
          c_seg[j] = c_seg[j-1]; c_tim[j] = c_tim[j-1]; c_liv[j] = c_liv[j-1]; j--;
        end
        c_seg[j] = s; c_tim[j] = t; c_liv[j] = l;
      end
      n = 0; acc = 0;
      for (int i = 0; i < c_cnt && n < NumSel; i++) begin
        if (c_tim[i] - c_tim[0] > {32'd0, win_r}) break;
        picks_q.push_back('{c_seg[i], 1'b0, c_ovf, 1'b0});
        n++;
        acc += {16'd0, c_liv[i]};
        if (acc >= {16'd0, bps_r}) break;
      end
      picks_q[$].last = 1'b1;
    end
    c_cnt = 0; c_ovf = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NOW_TIME:   now_r = val;
      REG_PROTECT:    prot_r = val;
      REG_AGE_WINDOW: win_r = val[15:0];
      default:        bps_r = val[15:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic [31:0] seg, logic [47:0] tm, logic [15:0] lv,
                           bit ok, bit last);
    if (!src_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, ok, lv, tm, seg};
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_beat(seg, tm, lv, ok, last);
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (picks_q.size() != 0) @(posedge clk_i);
    repeat (2 * NumCand + 64) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned n, bit narrow);
    logic [47:0] tm;
    for (int i = 0; i < n; i++) begin
      tm = narrow ? 48'd1000 + 48'($urandom_range(0, 12)) : 48'({$urandom, $urandom});
      send_beat($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 20), tm,
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300)),
                $urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0 || i == n - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (picks_q.size() == 0) begin
        $display("%0t: unexpected result seg=%h user=%b last=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        pick_t e;
        e = picks_q.pop_front();
        if ((!e.none && m_axis_tdata_o !== e.seg) || m_axis_tuser_o !== {e.ovf, e.none}
            || m_axis_tlast_o !== e.last) begin
          $display({"%0t: mismatch expected seg=%h none=%b ovf=%b last=%b",
                    " actual seg=%h user=%b last=%b"},
                   $time, e.seg, e.none, e.ovf, e.last, m_axis_tdata_o, m_axis_tuser_o,
                   m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (hold_sink) m_axis_tready_i <= 1'b0;
      else if (gap > 0) begin
        gap--; m_axis_tready_i <= 1'b0;
      end else if (!sink_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 16) - 1; m_axis_tready_i <= 1'b0;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || hold_sink)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("gc_segment_age_cluster_select verification failed");
      $finish;
    end
  end

  task automatic test_directed;
    send_beat(32'd5, 48'd0, 16'd0, 1'b0, 1'b1);
    drain();
    send_beat(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    send_beat(32'd3, 48'd10, 16'd1, 1'b1, 1'b0);
    send_beat(32'd2, 48'd10, 16'd1, 1'b1, 1'b0);
    send_beat(32'd2, 48'd14, 16'd1, 1'b1, 1'b0);
    send_beat(32'd9, 48'd15, 16'd1, 1'b1, 1'b1);
    drain();
    write_reg(REG_NOW_TIME, 48'd100);
    write_reg(REG_PROTECT, 48'd50);
    write_reg(REG_BLOCKS, 48'd3);
    send_beat(32'd1, 48'd50, 16'd9, 1'b1, 1'b0);
    send_beat(32'd2, 48'd100, 16'd9, 1'b1, 1'b0);
    send_beat(32'd3, 48'd101, 16'd2, 1'b1, 1'b0);
    send_beat(32'd4, 48'd49, 16'd1, 1'b1, 1'b0);
    send_beat(32'd5, 48'd52, 16'd0, 1'b1, 1'b1);
    drain();
    write_reg(REG_PROTECT, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_BLOCKS, 48'd0);
    write_reg(REG_AGE_WINDOW, 48'hFFFF);
    send_beat(32'd7, 48'd60, 16'd5, 1'b1, 1'b0);
    send_beat(32'd6, 48'd60, 16'd5, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_overflow;
    write_reg(REG_BLOCKS, 48'hFFFF);
    write_reg(REG_AGE_WINDOW, 48'd0);
    for (int i = 0; i < NumCand + 3; i++)
      send_beat($urandom_range(0, 200), 48'd1 + 48'($urandom_range(0, 1)), 16'd1, 1'b1,
                i == NumCand + 2);
    drain();
  endtask

  task automatic test_random;
    write_reg(REG_NOW_TIME, 48'd1005);
    write_reg(REG_PROTECT, 48'd1003);
    write_reg(REG_AGE_WINDOW, 48'd6);
    write_reg(REG_BLOCKS, 48'd400);
    sink_idle = 0; src_idle = 0;
    send_random(90, 1);
    drain();
    write_reg(REG_NOW_TIME, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_PROTECT, 48'd0);
    send_random(10, 0);
    drain();
    write_reg(REG_NOW_TIME, 48'd0);
    write_reg(REG_PROTECT, 48'd1);
    send_random(10, 0);
    drain();
  endtask

  task automatic test_backpressure;
    write_reg(REG_NOW_TIME, 48'd0);
    write_reg(REG_PROTECT, 48'd0);
    write_reg(REG_AGE_WINDOW, 48'd20);
    hold_sink = 1;
    fork
      begin repeat (3000) @(posedge clk_i); hold_sink = 0; end
      send_random(40, 1);
    join
    drain();
    sink_idle = 1; src_idle = 1;
    write_reg(REG_BLOCKS, 48'd1);
    send_random(40, 1);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    test_backpressure();
    if (errors == 0 && picks_q.size() == 0)
      $display("gc_segment_age_cluster_select verification clean");
    else
      $display("gc_segment_age_cluster_select verification failed");
    $finish;
  end
endmodule
